FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expands to a labeled concurrent assertion, or to nothing when
// assertions are switched off for the build.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// When a holds at a clock edge, b must hold at the same edge.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// When a holds at a clock edge, b must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: hw/rtl/cpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color palette package
// Command codes, register addresses and color helpers for the palette port.
// ----------------------------------------------------------------------------
package cpr_pkg;

    // Command codes.
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // Register map.
    localparam logic [15:0] ADDR_BG_INDEX  = 16'hFF68;
    localparam logic [15:0] ADDR_BG_DATA   = 16'hFF69;
    localparam logic [15:0] ADDR_OBJ_INDEX = 16'hFF6A;
    localparam logic [15:0] ADDR_OBJ_DATA  = 16'hFF6B;
    localparam logic [15:0] ADDR_BANK      = 16'hFF4F;

    // Value returned for a read of an unmapped address.
    localparam logic [7:0] UNKNOWN_READ = 8'hFF;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Palette geometry: 64 bytes per layer, split into even and odd byte banks.
    localparam int PAL_BYTES  = 64;
    localparam int BANK_DEPTH = PAL_BYTES / 2;
    localparam int POS_W      = $clog2(PAL_BYTES);
    localparam int ROW_W      = $clog2(BANK_DEPTH);

    // Widen a 5-bit channel to 8 bits by repeating its top bits.
    function automatic logic [7:0] widen5(input logic [4:0] c5);
        return {c5, c5[4:2]};
    endfunction

    // Build opaque ARGB from a 15-bit color; bit 15 is ignored.
    function automatic logic [31:0] to_argb(input logic [15:0] c);
        return {ALPHA_OPAQUE, widen5(c[4:0]), widen5(c[9:5]), widen5(c[14:10])};
    endfunction

endpackage

FILE: hw/rtl/cpr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
module cpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, and a read port that holds its data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/color_palette_ram_port.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color palette RAM port
// Background and sprite palette memories with index registers, register
// access from the CPU bus and per-pixel color lookup.
// ----------------------------------------------------------------------------
// The block accepts one beat per clock while o_stall is low and returns exactly one
// result beat per input beat. A result passes through the registered read of the
// synchronous palette RAM and then through the output register.
// Each layer's 64 palette bytes live in an even and an odd byte RAM, so the two
// bytes of a color are read in the same cycle. Writes land at acceptance and
// are visible to the very next beat. Per-byte valid bits, cleared by reset,
// make every palette byte read as zero until it is first written, so no
// clearing pass is needed after reset.
`include "assert_macros.svh"

module color_palette_ram_port (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_layer,
    input  logic [2:0]  i_palette_number,
    input  logic [1:0]  i_color_index,
    // Output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic [31:0] o_rgb_color
);

    typedef enum logic [1:0] {
        K_NONE,
        K_IMM,
        K_DATA,
        K_LOOKUP
    } t_kind;

    localparam int POS_W = cpr_pkg::POS_W;
    localparam int ROW_W = cpr_pkg::ROW_W;

    // Architectural registers.
    logic [7:0]                   r_bg_index;
    logic [7:0]                   r_obj_index;
    logic                         r_bank;
    logic [cpr_pkg::PAL_BYTES-1:0] r_bg_valid;
    logic [cpr_pkg::PAL_BYTES-1:0] r_obj_valid;

    // Read stage.
    logic       r_s1_valid;
    t_kind      r_s1_kind;
    logic [7:0] r_s1_imm;
    logic       r_s1_layer;
    logic       r_s1_odd;
    logic       r_s1_vld_even;
    logic       r_s1_vld_odd;

    // Output register.
    logic        r_out_valid;
    logic [7:0]  r_read_data;
    logic [31:0] r_rgb;

    logic accept;
    logic out_free;
    logic s1_move;

    logic is_write;
    logic is_lookup;

    t_kind      n_kind;
    logic [7:0] n_imm;
    logic       n_layer;
    logic       n_odd;
    logic [7:0] n_bg_index;
    logic [7:0] n_obj_index;

    logic [ROW_W-1:0] bg_row;
    logic [ROW_W-1:0] obj_row;
    logic [ROW_W-1:0] sel_row;
    logic             bg_wr;
    logic             obj_wr;
    logic [POS_W-1:0] bg_pos;
    logic [POS_W-1:0] obj_pos;

    logic [7:0] bg_even_q;
    logic [7:0] bg_odd_q;
    logic [7:0] obj_even_q;
    logic [7:0] obj_odd_q;
    logic [7:0] byte_lo;
    logic [7:0] byte_hi;
    logic [7:0] n_read_data;
    logic [31:0] n_rgb;

    // Handshake: the read stage advances whenever the output register is free.
    assign out_free = !r_out_valid || !i_stall;
    assign s1_move  = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    assign is_write  = (i_command == cpr_pkg::CMD_WRITE);
    assign is_lookup = (i_command == cpr_pkg::CMD_LOOKUP);

    assign bg_pos  = r_bg_index[POS_W-1:0];
    assign obj_pos = r_obj_index[POS_W-1:0];

    // Data register writes go to the bank picked by the low index bit.
    assign bg_wr  = accept && is_write && (i_address == cpr_pkg::ADDR_BG_DATA);
    assign obj_wr = accept && is_write && (i_address == cpr_pkg::ADDR_OBJ_DATA);

    // A lookup reads the color's row; a data read reads the index's row.
    assign bg_row  = is_lookup ? {i_palette_number, i_color_index} : bg_pos[POS_W-1:1];
    assign obj_row = is_lookup ? {i_palette_number, i_color_index} : obj_pos[POS_W-1:1];

    // Decode the beat into a result kind and the next index register values.
    always_comb begin
        n_kind      = K_NONE;
        n_imm       = 8'h00;
        n_layer     = i_layer;
        n_odd       = 1'b0;
        n_bg_index  = r_bg_index;
        n_obj_index = r_obj_index;
        case (i_command)
            cpr_pkg::CMD_WRITE: begin
                if (i_address == cpr_pkg::ADDR_BG_INDEX) begin
                    n_bg_index = i_write_data;
                end else if (i_address == cpr_pkg::ADDR_BG_DATA) begin
                    if (r_bg_index[7]) begin
                        n_bg_index = {2'b10, POS_W'(bg_pos + 1'b1)};
                    end
                end else if (i_address == cpr_pkg::ADDR_OBJ_INDEX) begin
                    n_obj_index = i_write_data;
                end else if (i_address == cpr_pkg::ADDR_OBJ_DATA) begin
                    if (r_obj_index[7]) begin
                        n_obj_index = {2'b10, POS_W'(obj_pos + 1'b1)};
                    end
                end
            end
            cpr_pkg::CMD_READ: begin
                n_kind = K_IMM;
                if (i_address == cpr_pkg::ADDR_BG_INDEX) begin
                    n_imm = r_bg_index;
                end else if (i_address == cpr_pkg::ADDR_BG_DATA) begin
                    n_kind  = K_DATA;
                    n_layer = 1'b0;
                    n_odd   = bg_pos[0];
                end else if (i_address == cpr_pkg::ADDR_OBJ_INDEX) begin
                    n_imm = r_obj_index;
                end else if (i_address == cpr_pkg::ADDR_OBJ_DATA) begin
                    n_kind  = K_DATA;
                    n_layer = 1'b1;
                    n_odd   = obj_pos[0];
                end else if (i_address == cpr_pkg::ADDR_BANK) begin
                    n_imm = {7'd0, r_bank};
                end else begin
                    n_imm = cpr_pkg::UNKNOWN_READ;
                end
            end
            cpr_pkg::CMD_LOOKUP: begin
                n_kind = K_LOOKUP;
            end
            default: begin
                n_kind = K_NONE;
            end
        endcase
    end

    assign sel_row = n_layer ? obj_row : bg_row;

    // Palette memories: even and odd byte banks for each layer. They are read
    // only when a beat is accepted, so a held beat keeps its read data.
    cpr_ram #(.WIDTH(8), .DEPTH(cpr_pkg::BANK_DEPTH)) u_bg_even (
        .i_clk   (i_clk),
        .i_we    (bg_wr && !bg_pos[0]),
        .i_waddr (bg_pos[POS_W-1:1]),
        .i_wdata (i_write_data),
        .i_re    (accept),
        .i_raddr (bg_row),
        .o_rdata (bg_even_q)
    );

    cpr_ram #(.WIDTH(8), .DEPTH(cpr_pkg::BANK_DEPTH)) u_bg_odd (
        .i_clk   (i_clk),
        .i_we    (bg_wr && bg_pos[0]),
        .i_waddr (bg_pos[POS_W-1:1]),
        .i_wdata (i_write_data),
        .i_re    (accept),
        .i_raddr (bg_row),
        .o_rdata (bg_odd_q)
    );

    cpr_ram #(.WIDTH(8), .DEPTH(cpr_pkg::BANK_DEPTH)) u_obj_even (
        .i_clk   (i_clk),
        .i_we    (obj_wr && !obj_pos[0]),
        .i_waddr (obj_pos[POS_W-1:1]),
        .i_wdata (i_write_data),
        .i_re    (accept),
        .i_raddr (obj_row),
        .o_rdata (obj_even_q)
    );

    cpr_ram #(.WIDTH(8), .DEPTH(cpr_pkg::BANK_DEPTH)) u_obj_odd (
        .i_clk   (i_clk),
        .i_we    (obj_wr && obj_pos[0]),
        .i_waddr (obj_pos[POS_W-1:1]),
        .i_wdata (i_write_data),
        .i_re    (accept),
        .i_raddr (obj_row),
        .o_rdata (obj_odd_q)
    );

    // Pick the layer's bytes; a byte never written reads as zero.
    assign byte_lo = r_s1_vld_even ? (r_s1_layer ? obj_even_q : bg_even_q) : 8'h00;
    assign byte_hi = r_s1_vld_odd  ? (r_s1_layer ? obj_odd_q  : bg_odd_q)  : 8'h00;

    // Form the result beat.
    always_comb begin
        n_read_data = 8'h00;
        n_rgb       = 32'h0;
        case (r_s1_kind)
            K_IMM:    n_read_data = r_s1_imm;
            K_DATA:   n_read_data = r_s1_odd ? byte_hi : byte_lo;
            K_LOOKUP: n_rgb = cpr_pkg::to_argb({byte_hi, byte_lo});
            default:  n_read_data = 8'h00;
        endcase
    end

    // Control state and architectural registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_index  <= 8'h00;
            r_obj_index <= 8'h00;
            r_bank      <= 1'b0;
            r_bg_valid  <= '0;
            r_obj_valid <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_bg_index  <= n_bg_index;
                r_obj_index <= n_obj_index;
                if (is_write && (i_address == cpr_pkg::ADDR_BANK)) begin
                    r_bank <= i_write_data[0];
                end
            end
            if (bg_wr) begin
                r_bg_valid[bg_pos] <= 1'b1;
            end
            if (obj_wr) begin
                r_obj_valid[obj_pos] <= 1'b1;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind     <= n_kind;
            r_s1_imm      <= n_imm;
            r_s1_layer    <= n_layer;
            r_s1_odd      <= n_odd;
            r_s1_vld_even <= n_layer ? r_obj_valid[{sel_row, 1'b0}]
                                     : r_bg_valid[{sel_row, 1'b0}];
            r_s1_vld_odd  <= n_layer ? r_obj_valid[{sel_row, 1'b1}]
                                     : r_bg_valid[{sel_row, 1'b1}];
        end
        if (s1_move) begin
            r_read_data <= n_read_data;
            r_rgb       <= n_rgb;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_rgb_color = r_rgb;

    // A beat in the read stage reaches the output register when it is free.
    `ASSERT_NEXT(a_s1_to_out, i_clk, i_rst_n, s1_move, r_out_valid)
    // Only a lookup gives a color, and a color is always opaque.
    `ASSERT_IMPL(a_opaque, i_clk, i_rst_n, o_valid && (o_rgb_color != 32'h0),
                 o_rgb_color[31:24] == cpr_pkg::ALPHA_OPAQUE)
    // A result never carries both a read byte and a color.
    `ASSERT_IMPL(a_one_field, i_clk, i_rst_n, o_valid && (o_read_data != 8'h00),
                 o_rgb_color == 32'h0)
    // Auto-increment keeps bit 7 set and bit 6 clear.
    `ASSERT_NEXT(a_bg_autoinc, i_clk, i_rst_n, bg_wr && r_bg_index[7],
                 r_bg_index[7] && !r_bg_index[6])

endmodule
